/* hdl/bilateral_filter_pixel_stream_core_macros.svh */
// Assertion macros shared by the bilateral filter RTL.
`ifndef BILATERAL_FILTER_PIXEL_STREAM_CORE_MACROS_SVH
`define BILATERAL_FILTER_PIXEL_STREAM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bfp_pkg.sv */
// Shared types and constants of the bilateral filter.
package bfp_pkg;

    // Item kinds carried on the input tuser field.
    typedef enum logic [1:0] {
        REQ_SPATIAL = 2'd0,
        REQ_RANGE   = 2'd1,
        REQ_PIXEL   = 2'd2,
        REQ_DRAIN   = 2'd3
    } req_kind_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_FILL_END,
        ST_CENTRE,
        ST_MAC,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } bfp_state_t;

    // Configuration register indexes.
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    // Q1.15 constants.
    localparam logic [15:0] Q_ONE  = 16'd32768;
    localparam logic [15:0] Q_HALF = 16'd16384;

    // Weight table write request.
    typedef struct packed {
        logic        spatial_we;
        logic        range_we;
        logic [7:0]  index;
        logic [15:0] value;
    } tbl_wr_t;

    // Multiply-accumulate control.
    typedef struct packed {
        logic issue;
        logic clear;
    } mac_ctrl_t;

endpackage

/* hdl/bilateral_filter_pixel_stream_core.sv */
// Top level of the bilateral filter: stream ports, line store and sequencer.
// Usage:
// The s_ channel carries one item per transaction: s_tuser gives the kind (spatial weight
// load, range weight load, pixel, drain tick) and s_tdata the index, weight and pixel.
// Weight loads go straight into the tables. Pixels arrive in raster order; the first
// RADIUS*W+RADIUS stream items fill the line store and give no result, after which
// every pixel or drain tick gives one filtered pixel on the m_ channel, with m_tlast
// on the last pixel of the frame. Drain ticks before the whole frame is in are dropped.
// For an item that gives a result, the window is read from the single-port line store
// one pixel a cycle into a chain of cells, then the chain rotates once through the
// weighting pipeline, and an eight-step divider forms the rounded quotient; when the
// weights sum to zero, the divider takes no steps and returns the centre pixel.
// Items without a result pass from the check state back to idle. s_tready is high only
// while the sequencer is idle.
// A result waits in the output register while the receiver stalls; the next item is
// accepted meanwhile, and its own result waits until the register is free.
// Reset (aresetn low, synchronous) restores 640x480 and starts a new frame; weight
// tables and the line store hold undefined data until written. A configuration write
// also restarts the frame.
module bilateral_filter_pixel_stream_core
    import bfp_pkg::*;
#(
    parameter int RADIUS     = 5,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [12:0] cfg_wr_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // table_index[7:0], weight_value[23:8], pixel_in[31:24]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // pixel_out[7:0]
    output logic        m_tlast
);

    localparam int SPAN      = 2 * RADIUS + 1;
    localparam int TAPS      = SPAN * SPAN;
    localparam int SIDE      = RADIUS + 1;
    localparam int SP_DEPTH  = SIDE * SIDE;
    localparam int SP_W      = $clog2(SP_DEPTH);
    localparam int RING_ROWS = 3 * RADIUS + 1;
    localparam int RMOD_W    = $clog2(RING_ROWS);
    localparam int LINE_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int LA_W      = $clog2(LINE_DEPTH);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int WW        = $clog2(MAX_WIDTH + 1);
    localparam int HW        = $clog2(MAX_HEIGHT + 1);
    localparam int XW        = COL_W + 2;
    localparam int YW        = ROW_W + 2;
    localparam int TAP_W     = $clog2(SPAN);
    localparam int POS_W     = $clog2(MAX_WIDTH * (MAX_HEIGHT + RADIUS) + RADIUS + 1);
    localparam int NUM_W     = $clog2(TAPS * 32768 * 255 + 1);
    localparam int DEN_W     = $clog2(TAPS * 32768 + 1);
    localparam int W_RST     = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RST     = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    bfp_state_t state_reg, state_next;

    logic             accept_in;
    req_kind_t        kind_in;
    req_kind_t        kind_reg;
    logic [7:0]       pixel_reg;

    logic [WW-1:0]    w_eff_reg;
    logic [HW-1:0]    h_eff_reg;
    logic [POS_W-1:0] total_reg, lat_reg;
    logic [31:0]      cfg_val;

    logic [POS_W-1:0]  in_pos_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [RMOD_W-1:0] in_rowmod_reg;
    logic [COL_W-1:0]  out_x_reg;
    logic [ROW_W-1:0]  out_y_reg;
    logic [RMOD_W-1:0] out_ymod_reg;

    logic [TAP_W-1:0]  tap_dy_reg, tap_dx_reg;
    logic signed [YW-1:0] row_u_reg;
    logic signed [YW-1:0] row_u_next, row_u_init;
    logic [RMOD_W-1:0] rmod_reg;
    logic [RMOD_W-1:0] rmod_step, rmod_init;
    logic              tap_last, tap_row_end;

    logic signed [XW-1:0] col_u;
    logic [COL_W-1:0]  rd_col;
    logic [LA_W-1:0]   rd_addr, wr_addr;
    logic [7:0]        line_mem [LINE_DEPTH];
    logic [7:0]        line_rd_reg;
    logic              rd_valid_reg;

    logic              p_lt_total, p_lt_lat, eof;
    logic              chain_shift, chain_rotate;
    logic [7:0]        chain_head, chain_centre, centre_reg;
    logic [TAP_W-1:0]  ady, adx;
    logic [SP_W-1:0]   sp_addr;

    tbl_wr_t           tbl_wr;
    mac_ctrl_t         mac_ctrl;
    logic              mac_busy;
    logic [NUM_W-1:0]  mac_num;
    logic [DEN_W-1:0]  mac_den;
    logic              div_start, div_done;
    logic [7:0]        div_q;

    logic              out_load;
    logic              m_valid_reg, m_last_reg;
    logic [7:0]        m_pixel_reg;

    // Input decode and weight table writes.
    assign accept_in = s_tvalid && s_tready;
    assign kind_in   = req_kind_t'(s_tuser);
    assign tbl_wr.spatial_we = accept_in && (kind_in == REQ_SPATIAL)
                               && (32'(s_tdata[7:0]) < SP_DEPTH);
    assign tbl_wr.range_we   = accept_in && (kind_in == REQ_RANGE);
    assign tbl_wr.index      = s_tdata[7:0];
    assign tbl_wr.value      = s_tdata[23:8];

    // Frame position tests.
    assign p_lt_total = in_pos_reg < total_reg;
    assign p_lt_lat   = in_pos_reg < lat_reg;
    assign eof = (out_x_reg == COL_W'(w_eff_reg - WW'(1)))
                 && (out_y_reg == ROW_W'(h_eff_reg - HW'(1)));

    // Window tap counters and the clamped row of the next tap row.
    assign tap_row_end = (tap_dx_reg == TAP_W'(SPAN - 1));
    assign tap_last    = tap_row_end && (tap_dy_reg == TAP_W'(SPAN - 1));
    assign row_u_next  = row_u_reg + YW'(1);
    assign rmod_step   = (rmod_reg == RMOD_W'(RING_ROWS - 1)) ? '0 : rmod_reg + RMOD_W'(1);
    assign row_u_init  = $signed(YW'(out_y_reg)) - $signed(YW'(RADIUS));
    assign rmod_init   = row_u_init[YW-1] ? '0 :
                         (out_ymod_reg >= RMOD_W'(RADIUS)) ? out_ymod_reg - RMOD_W'(RADIUS) :
                         RMOD_W'(out_ymod_reg + RMOD_W'(RING_ROWS - RADIUS));

    // Clamped column of the current tap.
    assign col_u  = $signed(XW'(out_x_reg)) + $signed(XW'(tap_dx_reg)) - $signed(XW'(RADIUS));
    assign rd_col = col_u[XW-1] ? '0 :
                    (col_u[XW-2:0] >= (XW-1)'(w_eff_reg)) ? COL_W'(w_eff_reg - WW'(1)) :
                    col_u[COL_W-1:0];
    assign rd_addr = LA_W'(rmod_reg) * LA_W'(MAX_WIDTH) + LA_W'(rd_col);
    assign wr_addr = LA_W'(in_rowmod_reg) * LA_W'(MAX_WIDTH) + LA_W'(in_col_reg);

    // Spatial table address from the tap offsets.
    assign ady = (tap_dy_reg >= TAP_W'(RADIUS)) ? tap_dy_reg - TAP_W'(RADIUS)
                                                : TAP_W'(RADIUS) - tap_dy_reg;
    assign adx = (tap_dx_reg >= TAP_W'(RADIUS)) ? tap_dx_reg - TAP_W'(RADIUS)
                                                : TAP_W'(RADIUS) - tap_dx_reg;
    assign sp_addr = SP_W'(ady) * SP_W'(SIDE) + SP_W'(adx);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        state_next   = state_reg;
        mac_ctrl     = '0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        chain_shift  = rd_valid_reg;
        chain_rotate = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept_in && (kind_in == REQ_PIXEL || kind_in == REQ_DRAIN)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if ((kind_reg == REQ_DRAIN && p_lt_total) || p_lt_lat) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (tap_last) begin
                    state_next = ST_FILL_END;
                end
            end
            ST_FILL_END: begin
                state_next = ST_CENTRE;
            end
            ST_CENTRE: begin
                mac_ctrl.clear = 1'b1;
                state_next     = ST_MAC;
            end
            ST_MAC: begin
                chain_shift    = 1'b1;
                chain_rotate   = 1'b1;
                mac_ctrl.issue = 1'b1;
                if (tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Frame size registers; a write also restarts the frame.
    assign cfg_val = 32'(cfg_wr_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_eff_reg <= WW'(W_RST);
            h_eff_reg <= HW'(H_RST);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_val[11:0] == '0) begin
                        w_eff_reg <= WW'(1);
                    end else if (32'(cfg_val[11:0]) > MAX_WIDTH) begin
                        w_eff_reg <= WW'(MAX_WIDTH);
                    end else begin
                        w_eff_reg <= WW'(cfg_val[11:0]);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (cfg_val[12:0] == '0) begin
                        h_eff_reg <= HW'(1);
                    end else if (32'(cfg_val[12:0]) > MAX_HEIGHT) begin
                        h_eff_reg <= HW'(MAX_HEIGHT);
                    end else begin
                        h_eff_reg <= HW'(cfg_val[12:0]);
                    end
                end
                default: begin
                    w_eff_reg <= w_eff_reg;
                end
            endcase
        end
    end

    // Frame size products, refreshed every cycle.
    always_ff @(posedge aclk) begin
        total_reg <= POS_W'(w_eff_reg) * POS_W'(h_eff_reg);
        lat_reg   <= POS_W'(w_eff_reg) * POS_W'(RADIUS) + POS_W'(RADIUS);
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            kind_reg  <= kind_in;
            pixel_reg <= s_tdata[31:24];
        end
    end

    // Stream positions and window tap counters.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr_en) begin
            in_pos_reg    <= '0;
            in_col_reg    <= '0;
            in_rowmod_reg <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_ymod_reg  <= '0;
            tap_dy_reg    <= '0;
            tap_dx_reg    <= '0;
            row_u_reg     <= '0;
            rmod_reg      <= '0;
        end else begin
            case (state_reg)
                ST_CHECK: begin
                    if (!(kind_reg == REQ_DRAIN && p_lt_total)) begin
                        in_pos_reg <= in_pos_reg + POS_W'(1);
                    end
                    if (kind_reg == REQ_PIXEL && p_lt_total) begin
                        if (in_col_reg == COL_W'(w_eff_reg - WW'(1))) begin
                            in_col_reg    <= '0;
                            in_rowmod_reg <= (in_rowmod_reg == RMOD_W'(RING_ROWS - 1)) ? '0
                                             : in_rowmod_reg + RMOD_W'(1);
                        end else begin
                            in_col_reg <= in_col_reg + COL_W'(1);
                        end
                    end
                    tap_dy_reg <= '0;
                    tap_dx_reg <= '0;
                    row_u_reg  <= row_u_init;
                    rmod_reg   <= rmod_init;
                end
                ST_FETCH, ST_MAC: begin
                    if (tap_row_end) begin
                        tap_dx_reg <= '0;
                        tap_dy_reg <= tap_dy_reg + TAP_W'(1);
                        row_u_reg  <= row_u_next;
                        if (row_u_next[YW-1] || row_u_next == '0) begin
                            rmod_reg <= '0;
                        end else if (row_u_next[YW-2:0] < (YW-1)'(h_eff_reg)) begin
                            rmod_reg <= rmod_step;
                        end
                    end else begin
                        tap_dx_reg <= tap_dx_reg + TAP_W'(1);
                    end
                end
                ST_CENTRE: begin
                    tap_dy_reg <= '0;
                    tap_dx_reg <= '0;
                end
                ST_OUT: begin
                    if (out_load) begin
                        if (eof) begin
                            in_pos_reg    <= '0;
                            in_col_reg    <= '0;
                            in_rowmod_reg <= '0;
                            out_x_reg     <= '0;
                            out_y_reg     <= '0;
                            out_ymod_reg  <= '0;
                        end else if (out_x_reg == COL_W'(w_eff_reg - WW'(1))) begin
                            out_x_reg    <= '0;
                            out_y_reg    <= out_y_reg + ROW_W'(1);
                            out_ymod_reg <= (out_ymod_reg == RMOD_W'(RING_ROWS - 1)) ? '0
                                            : out_ymod_reg + RMOD_W'(1);
                        end else begin
                            out_x_reg <= out_x_reg + COL_W'(1);
                        end
                    end
                end
                default: begin
                    in_pos_reg <= in_pos_reg;
                end
            endcase
        end
    end

    // Line store: pixel writes, window reads.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CHECK && kind_reg == REQ_PIXEL && p_lt_total) begin
            line_mem[wr_addr] <= pixel_reg;
        end
        if (state_reg == ST_FETCH) begin
            line_rd_reg <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= (state_reg == ST_FETCH);
        end
    end

    // Centre pixel held for the weighting pass.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CENTRE) begin
            centre_reg <= chain_centre;
        end
    end

    bfp_window_chain #(
        .TAPS   (TAPS),
        .CENTRE (RADIUS * SPAN + RADIUS)
    ) u_chain (
        .aclk      (aclk),
        .shift_en  (chain_shift),
        .rotate    (chain_rotate),
        .fill_data (line_rd_reg),
        .head      (chain_head),
        .centre    (chain_centre)
    );

    bfp_weight_mac #(
        .SP_DEPTH (SP_DEPTH),
        .SP_W     (SP_W),
        .NUM_W    (NUM_W),
        .DEN_W    (DEN_W)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tbl_wr  (tbl_wr),
        .ctrl    (mac_ctrl),
        .sp_addr (sp_addr),
        .nb      (chain_head),
        .centre  (centre_reg),
        .num     (mac_num),
        .den     (mac_den),
        .busy    (mac_busy)
    );

    bfp_divider #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mac_num),
        .den     (mac_den),
        .centre  (centre_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_pixel_reg <= div_q;
            m_last_reg  <= eof;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pixel_reg;
    assign m_tlast  = m_last_reg;

    // Checks.
`include "bilateral_filter_pixel_stream_core_macros.svh"

    `BFP_ASSERT_NEXT(a_out_only_from_out, aclk, aresetn, !m_valid_reg && state_reg != ST_OUT, !m_valid_reg, "result appeared without a finished filter pass")
    `BFP_ASSERT_NOW(a_idle_mac_quiet, aclk, aresetn, state_reg == ST_IDLE, !mac_busy, "weighting pipeline busy while idle")
    `BFP_ASSERT_NEXT(a_eof_restarts, aclk, aresetn, out_load && eof, in_pos_reg == '0 && out_x_reg == '0, "frame position not cleared after last pixel")

endmodule

/* hdl/bfp_cell.sv */
// One window cell: a pixel register that takes either its neighbour or the loop input.
module bfp_cell
    import bfp_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  logic       sel_loop,
    input  logic [7:0] shift_in,
    input  logic [7:0] loop_in,
    output logic [7:0] q
);

    logic [7:0] pix_reg;

    // Move one place along the chain when enabled.
    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= sel_loop ? loop_in : shift_in;
        end
    end

    assign q = pix_reg;

endmodule

/* hdl/bfp_window_chain.sv */
// Chain of window cells: filled from the line store, then rotated past the weighting unit.
module bfp_window_chain
    import bfp_pkg::*;
#(
    parameter int TAPS   = 121,
    parameter int CENTRE = 60
) (
    input  logic       aclk,
    input  logic       shift_en,
    input  logic       rotate,
    input  logic [7:0] fill_data,
    output logic [7:0] head,
    output logic [7:0] centre
);

    logic [7:0] cell_q [TAPS];

    // Each cell takes the value of the cell above it; the tail takes new or recirculated data.
    for (genvar i = 0; i < TAPS; i++) begin : g_cell
        if (i == TAPS - 1) begin : g_tail
            bfp_cell u_cell (
                .aclk     (aclk),
                .en       (shift_en),
                .sel_loop (rotate),
                .shift_in (fill_data),
                .loop_in  (cell_q[0]),
                .q        (cell_q[i])
            );
        end else begin : g_body
            bfp_cell u_cell (
                .aclk     (aclk),
                .en       (shift_en),
                .sel_loop (1'b0),
                .shift_in (cell_q[i+1]),
                .loop_in  (cell_q[i+1]),
                .q        (cell_q[i])
            );
        end
    end

    assign head   = cell_q[0];
    assign centre = cell_q[CENTRE];

endmodule

/* hdl/bfp_weight_mac.sv */
// Weight tables and the pipelined weight and accumulate unit.
module bfp_weight_mac
    import bfp_pkg::*;
#(
    parameter int SP_DEPTH = 36,
    parameter int SP_W     = 6,
    parameter int NUM_W    = 31,
    parameter int DEN_W    = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbl_wr_t          tbl_wr,
    input  mac_ctrl_t        ctrl,
    input  logic [SP_W-1:0]  sp_addr,
    input  logic [7:0]       nb,
    input  logic [7:0]       centre,
    output logic [NUM_W-1:0] num,
    output logic [DEN_W-1:0] den,
    output logic             busy
);

    logic [15:0] spatial_mem [SP_DEPTH];
    logic [15:0] range_mem [256];
    logic [15:0] wt_sat;
    logic [7:0]  diff;
    logic [31:0] rnd_sum;

    logic [15:0] sw1_reg, rw1_reg;
    logic [7:0]  nb1_reg, nb2_reg, nb3_reg;
    logic [31:0] prod2_reg;
    logic [15:0] wgt3_reg, wgt4_reg;
    logic [23:0] pw4_reg;
    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;

    // Loaded weights are limited to 1.0.
    assign wt_sat  = (tbl_wr.value > Q_ONE) ? Q_ONE : tbl_wr.value;
    assign diff    = (nb > centre) ? (nb - centre) : (centre - nb);
    assign rnd_sum = prod2_reg + 32'(Q_HALF);

    // Table writes and registered table reads.
    always_ff @(posedge aclk) begin
        if (tbl_wr.spatial_we) begin
            spatial_mem[tbl_wr.index[SP_W-1:0]] <= wt_sat;
        end
        if (tbl_wr.range_we) begin
            range_mem[tbl_wr.index] <= wt_sat;
        end
        sw1_reg <= spatial_mem[sp_addr];
        rw1_reg <= range_mem[diff];
    end

    // Datapath stages: weight product, rounding, weighted pixel.
    always_ff @(posedge aclk) begin
        nb1_reg   <= nb;
        prod2_reg <= sw1_reg * rw1_reg;
        nb2_reg   <= nb1_reg;
        wgt3_reg  <= rnd_sum[30:15];
        nb3_reg   <= nb2_reg;
        pw4_reg   <= wgt3_reg * nb3_reg;
        wgt4_reg  <= wgt3_reg;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= ctrl.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Numerator and denominator sums.
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            num_reg <= '0;
            den_reg <= '0;
        end else if (v4_reg) begin
            num_reg <= num_reg + NUM_W'(pw4_reg);
            den_reg <= den_reg + DEN_W'(wgt4_reg);
        end
    end

    assign num  = num_reg;
    assign den  = den_reg;
    assign busy = v1_reg | v2_reg | v3_reg | v4_reg;

endmodule

/* hdl/bfp_divider.sv */
// Rounded restoring divider, one quotient bit per cycle.
module bfp_divider
    import bfp_pkg::*;
#(
    parameter int NUM_W = 31,
    parameter int DEN_W = 22
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [7:0]       centre,
    output logic             done,
    output logic [7:0]       quot
);

    localparam int REM_W = NUM_W + 1;
    localparam int DSH_W = DEN_W + 7;
    localparam int CW    = (REM_W > DSH_W) ? REM_W : DSH_W;

    logic [REM_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [7:0]       q_reg;
    logic [2:0]       cnt_reg;
    logic             active_reg, done_reg;
    logic             rem_ge;

    assign rem_ge = CW'(rem_reg) >= CW'(dsh_reg);

    // Iteration control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                active_reg <= (den != '0);
                done_reg   <= (den == '0);
                cnt_reg    <= '0;
            end else if (active_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient; the quotient is known to stay below 256.
    always_ff @(posedge aclk) begin
        if (start) begin
            if (den == '0) begin
                q_reg <= centre;
            end else begin
                q_reg <= '0;
            end
            rem_reg <= REM_W'(num) + REM_W'(den >> 1);
            dsh_reg <= DSH_W'(den) << 7;
        end else if (active_reg) begin
            if (rem_ge) begin
                rem_reg <= REM_W'(CW'(rem_reg) - CW'(dsh_reg));
            end
            q_reg   <= {q_reg[6:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
